### hdl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, constants and controller/datapath bundles for the serial
// frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int P_PAYLOAD_MAX = 64;

    localparam int RX_W      = 8;
    localparam int FUNC_W    = 16;
    localparam int LEN_W     = 16;
    localparam int CFG_W     = 7;
    localparam int OUT_LEN_W = 7;
    localparam int IDX_W     = 6;

    localparam logic [RX_W-1:0]  START_BYTE      = 8'hFE;
    localparam logic [CFG_W-1:0] CFG_MAX_LEN_RST = 7'd64;

    // Commands from controller to datapath
    typedef struct packed {
        logic clr_frame;   // clear function, length and fill index
        logic start_xor;   // seed checksum with the start byte
        logic acc_xor;     // fold current byte into checksum
        logic ld_func_hi;
        logic ld_func_lo;
        logic ld_len_hi;
        logic ld_len_lo;
        logic data_wr;     // write payload byte, advance fill index
        logic emit_clr;    // restart emit index
        logic emit_rd;     // issue buffer read at emit index
        logic out_load;    // load output register
        logic emit_adv;    // advance emit index
    } t_sfd_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic is_start;
        logic len_zero;    // length being completed is zero
        logic len_over;    // length being completed exceeds limit
        logic data_last;   // current payload byte is the final one
        logic xor_match;
        logic emit_last;
        logic out_free;
    } t_sfd_sts;

endpackage

### hdl/sfd_ram.sv
// ----------------------------------------------------------------------------
// sfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// sfd_ctrl
// Frame receive and payload emit sequencer.
// ----------------------------------------------------------------------------
module sfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sfd_pkg::t_sfd_sts i_sts,
    output sfd_pkg::t_sfd_cmd o_cmd
);
    import sfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FUNC_HI,
        S_FUNC_LO,
        S_LEN_HI,
        S_LEN_LO,
        S_DATA,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_WAIT
    } t_state;

    t_state   r_state, n_state;
    logic     r_in_ready, n_in_ready;
    logic     accept;
    t_sfd_cmd cmd;

    assign accept = i_in_valid && r_in_ready;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cmd.clr_frame = 1'b1;
                    if (i_sts.is_start) begin
                        cmd.start_xor = 1'b1;
                        n_state       = S_FUNC_HI;
                    end
                end
            end
            S_FUNC_HI: begin
                if (accept) begin
                    cmd.ld_func_hi = 1'b1;
                    cmd.acc_xor    = 1'b1;
                    n_state        = S_FUNC_LO;
                end
            end
            S_FUNC_LO: begin
                if (accept) begin
                    cmd.ld_func_lo = 1'b1;
                    cmd.acc_xor    = 1'b1;
                    n_state        = S_LEN_HI;
                end
            end
            S_LEN_HI: begin
                if (accept) begin
                    cmd.ld_len_hi = 1'b1;
                    cmd.acc_xor   = 1'b1;
                    n_state       = S_LEN_LO;
                end
            end
            S_LEN_LO: begin
                if (accept) begin
                    cmd.ld_len_lo = 1'b1;
                    cmd.acc_xor   = 1'b1;
                    if (i_sts.len_zero) begin
                        n_state = S_CHECK;
                    end else if (i_sts.len_over) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (accept) begin
                    cmd.data_wr = 1'b1;
                    cmd.acc_xor = 1'b1;
                    if (i_sts.data_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (accept) begin
                    if (i_sts.xor_match) begin
                        cmd.emit_clr = 1'b1;
                        n_state      = S_EMIT_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                n_state     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.emit_adv = 1'b1;
                        n_state      = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state != S_EMIT_RD) && (n_state != S_EMIT_WAIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

### hdl/sfd_dpath.sv
// ----------------------------------------------------------------------------
// sfd_dpath
// Header registers, checksum, payload buffer and output register.
// ----------------------------------------------------------------------------
module sfd_dpath #(
    parameter int PAYLOAD_MAX = sfd_pkg::P_PAYLOAD_MAX
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sfd_pkg::RX_W-1:0]      i_rx_byte,
    input  logic                          i_cfg_wr,
    input  logic [sfd_pkg::CFG_W-1:0]     i_cfg_data,
    input  sfd_pkg::t_sfd_cmd             i_cmd,
    output sfd_pkg::t_sfd_sts             o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfd_pkg::FUNC_W-1:0]    o_function_code,
    output logic [sfd_pkg::OUT_LEN_W-1:0] o_payload_length,
    output logic [sfd_pkg::IDX_W-1:0]     o_byte_index,
    output logic [sfd_pkg::RX_W-1:0]      o_payload_byte,
    output logic                          o_last_of_frame
);
    import sfd_pkg::*;

    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CW = $clog2(PAYLOAD_MAX + 1);
    localparam logic [CFG_W-1:0] LIMIT_CAP = CFG_W'(PAYLOAD_MAX);

    logic [CFG_W-1:0]     r_max_len;
    logic [FUNC_W-1:0]    r_func;
    logic [LEN_W-1:0]     r_len;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        r_emit_idx;
    logic [RX_W-1:0]      r_xor;

    logic                 r_out_valid;
    logic [FUNC_W-1:0]    r_out_func;
    logic [OUT_LEN_W-1:0] r_out_len;
    logic [IDX_W-1:0]     r_out_idx;
    logic [RX_W-1:0]      r_out_byte;
    logic                 r_out_last;

    logic [CFG_W-1:0]     limit;
    logic [LEN_W-1:0]     len_full;
    logic [CW-1:0]        fill_next;
    logic [CW-1:0]        emit_next;
    logic [RX_W-1:0]      rd_data;
    logic                 len_is_zero;

    assign limit       = (r_max_len > LIMIT_CAP) ? LIMIT_CAP : r_max_len;
    assign len_full    = {r_len[LEN_W-1:RX_W], i_rx_byte};
    assign fill_next   = r_fill + 1'b1;
    assign emit_next   = r_emit_idx + 1'b1;
    assign len_is_zero = (r_len == '0);

    assign o_sts.is_start  = (i_rx_byte == START_BYTE);
    assign o_sts.len_zero  = (len_full == '0);
    assign o_sts.len_over  = (len_full > LEN_W'(limit));
    assign o_sts.data_last = (LEN_W'(fill_next) >= r_len);
    assign o_sts.xor_match = (r_xor == i_rx_byte);
    assign o_sts.emit_last = len_is_zero || (LEN_W'(emit_next) == r_len);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    sfd_ram #(
        .WIDTH (RX_W),
        .DEPTH (PAYLOAD_MAX),
        .AW    (AW)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.data_wr),
        .i_wr_addr (r_fill[AW-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (i_cmd.emit_rd),
        .i_rd_addr (r_emit_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= CFG_MAX_LEN_RST;
            r_func      <= '0;
            r_len       <= '0;
            r_fill      <= '0;
            r_emit_idx  <= '0;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                r_max_len <= i_cfg_data;
            end
            if (i_cmd.clr_frame) begin
                r_func <= '0;
                r_len  <= '0;
                r_fill <= '0;
            end
            if (i_cmd.start_xor) begin
                r_xor <= START_BYTE;
            end else if (i_cmd.acc_xor) begin
                r_xor <= r_xor ^ i_rx_byte;
            end
            if (i_cmd.ld_func_hi) begin
                r_func <= {i_rx_byte, 8'h00};
            end
            if (i_cmd.ld_func_lo) begin
                r_func <= {r_func[FUNC_W-1:RX_W], i_rx_byte};
            end
            if (i_cmd.ld_len_hi) begin
                r_len <= {i_rx_byte, 8'h00};
            end
            if (i_cmd.ld_len_lo) begin
                r_len <= len_full;
            end
            if (i_cmd.data_wr) begin
                r_fill <= fill_next;
            end
            if (i_cmd.emit_clr) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit_adv) begin
                r_emit_idx <= emit_next;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_func <= r_func;
            r_out_len  <= r_len[OUT_LEN_W-1:0];
            r_out_idx  <= IDX_W'(r_emit_idx);
            r_out_byte <= len_is_zero ? '0 : rd_data;
            r_out_last <= o_sts.emit_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_function_code  = r_out_func;
    assign o_payload_length = r_out_len;
    assign o_byte_index     = r_out_idx;
    assign o_payload_byte   = r_out_byte;
    assign o_last_of_frame  = r_out_last;

endmodule

### hdl/serial_frame_decoder.sv
// Flow: one rx beat per cycle while receiving; after a good checksum, each
//   result takes a buffer read, then an output load, with input held off;
//   the load waits while the output register holds an untaken result.
// The separate read step comes from the registered read port of the payload buffer.
// Reset: synchronous, active low; clears the sequencer, checksum, header
//   registers and output valid, and sets max_payload_length to 64.
// ----------------------------------------------------------------------------
// serial_frame_decoder
// Deframes a byte stream of the form: start byte 0xFE, 16-bit function code,
// 16-bit length, payload, XOR checksum. On a good checksum, replays the
// buffered payload, one beat per byte (one zero beat if empty), last marked.
// ----------------------------------------------------------------------------
module serial_frame_decoder #(
    parameter int PAYLOAD_MAX = sfd_pkg::P_PAYLOAD_MAX
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // rx byte channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [sfd_pkg::RX_W-1:0]      i_rx_byte,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sfd_pkg::CFG_W-1:0]     i_max_payload_length,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [sfd_pkg::FUNC_W-1:0]    o_function_code,
    output logic [sfd_pkg::OUT_LEN_W-1:0] o_payload_length,
    output logic [sfd_pkg::IDX_W-1:0]     o_byte_index,
    output logic [sfd_pkg::RX_W-1:0]      o_payload_byte,
    output logic                          o_last_of_frame
);
    import sfd_pkg::*;

    t_sfd_cmd cmd;
    t_sfd_sts sts;
    logic     cfg_wr;

    // The limit register may be written at any time; take every beat.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    // Sequencer: walks header, payload and checksum beats, then drives the
    // replay of the buffer toward the output register.
    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: header capture, running XOR, payload buffer, output register.
    // The output register lets the next result load in the cycle that the
    // current one is taken.
    sfd_dpath #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_wr         (cfg_wr),
        .i_cfg_data       (i_max_payload_length),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_function_code  (o_function_code),
        .o_payload_length (o_payload_length),
        .o_byte_index     (o_byte_index),
        .o_payload_byte   (o_payload_byte),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule

### hdl/sfd_checker.sv
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the serial frame decoder result channel.
// ----------------------------------------------------------------------------
module sfd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [sfd_pkg::FUNC_W-1:0]    o_function_code,
    input logic [sfd_pkg::OUT_LEN_W-1:0] o_payload_length,
    input logic [sfd_pkg::IDX_W-1:0]     o_byte_index,
    input logic [sfd_pkg::RX_W-1:0]      o_payload_byte,
    input logic                          o_last_of_frame
);
    import sfd_pkg::*;

    // No result survives reset.
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_function_code)
            && $stable(o_byte_index) && $stable(o_payload_byte)
            && $stable(o_last_of_frame))
        else $error("stalled result changed");

    // Index stays inside the frame.
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (OUT_LEN_W'(o_byte_index) < o_payload_length)
            || (o_payload_length == '0 && o_byte_index == '0))
        else $error("byte index outside frame");

    // Last marker sits exactly on the final index.
    a_last_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_last_of_frame == ((OUT_LEN_W'(o_byte_index) + 1'b1
            == o_payload_length) || (o_payload_length == '0)))
        else $error("last marker misplaced");

    // Empty frame carries a zero byte.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_payload_length == '0 |-> o_payload_byte == '0)
        else $error("empty frame with nonzero byte");

endmodule

bind serial_frame_decoder sfd_checker u_sfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_function_code  (o_function_code),
    .o_payload_length (o_payload_length),
    .o_byte_index     (o_byte_index),
    .o_payload_byte   (o_payload_byte),
    .o_last_of_frame  (o_last_of_frame)
);

### verif/sfd_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfd_monitor
// Watches the rx, configuration and result channels of the serial frame
// decoder, deframes every accepted rx beat on its own and compares each
// result beat against the oldest beat still due.
// ----------------------------------------------------------------------------
module sfd_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [sfd_pkg::RX_W-1:0]      i_rx_byte,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [sfd_pkg::CFG_W-1:0]     i_cfg_max_len,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [sfd_pkg::FUNC_W-1:0]    i_function_code,
    input  logic [sfd_pkg::OUT_LEN_W-1:0] i_payload_length,
    input  logic [sfd_pkg::IDX_W-1:0]     i_byte_index,
    input  logic [sfd_pkg::RX_W-1:0]      i_payload_byte,
    input  logic                          i_last_of_frame,
    output int                            o_fail_count,
    output int                            o_beats_due
);
    import sfd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FUNC_HI,
        PH_FUNC_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_DATA,
        PH_CHECK
    } t_rx_phase;

    typedef struct packed {
        logic [FUNC_W-1:0]    function_code;
        logic [OUT_LEN_W-1:0] payload_length;
        logic [IDX_W-1:0]     byte_index;
        logic [RX_W-1:0]      payload_byte;
        logic                 last_of_frame;
    } t_frame_beat;

    t_rx_phase          phase;
    logic [FUNC_W-1:0]  func_acc;
    logic [LEN_W-1:0]   len_acc;
    logic [6:0]         fill_ptr;
    logic [RX_W-1:0]    xor_acc;
    logic [RX_W-1:0]    payload_mem [P_PAYLOAD_MAX];
    logic [CFG_W-1:0]   max_len;
    t_frame_beat        beats_due [$];
    int                 fail_count = 0;

    // Advance the deframer by one rx byte; queue the beats a good frame yields.
    task automatic deframe_byte(input logic [RX_W-1:0] b);
        int unsigned limit;
        int unsigned count;
        int unsigned i;
        t_frame_beat beat;
        case (phase)
            PH_FUNC_HI: begin
                func_acc = {b, 8'h00};
                xor_acc ^= b;
                phase = PH_FUNC_LO;
            end
            PH_FUNC_LO: begin
                func_acc[7:0] = b;
                xor_acc ^= b;
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_acc = {b, 8'h00};
                xor_acc ^= b;
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_acc[7:0] = b;
                xor_acc ^= b;
                limit = (max_len > P_PAYLOAD_MAX) ? P_PAYLOAD_MAX : max_len;
                if (len_acc == 0) begin
                    phase = PH_CHECK;
                end else if (len_acc > limit) begin
                    phase = PH_IDLE;
                end else begin
                    phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (fill_ptr < P_PAYLOAD_MAX) begin
                    payload_mem[fill_ptr] = b;
                end
                xor_acc ^= b;
                fill_ptr = fill_ptr + 7'd1;
                if (fill_ptr >= len_acc) begin
                    phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                if (xor_acc == b) begin
                    count = (len_acc == 0) ? 1 :
                            ((len_acc > P_PAYLOAD_MAX) ? P_PAYLOAD_MAX : len_acc);
                    for (i = 0; i < count; i++) begin
                        beat.function_code  = func_acc;
                        beat.payload_length = len_acc[OUT_LEN_W-1:0];
                        beat.byte_index     = IDX_W'(i);
                        beat.payload_byte   = (len_acc == 0) ? 8'h00 : payload_mem[i];
                        beat.last_of_frame  = (i + 1 == count);
                        beats_due.push_back(beat);
                    end
                end
                phase = PH_IDLE;
            end
            default: begin
                phase    = PH_IDLE;
                func_acc = '0;
                len_acc  = '0;
                fill_ptr = '0;
                if (b == START_BYTE) begin
                    xor_acc = START_BYTE;
                    phase   = PH_FUNC_HI;
                end
            end
        endcase
    endtask

    function automatic bit field_ok(input string name, input logic [15:0] want,
                                    input logic [15:0] got);
        if (want === got) return 1'b1;
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, want, got);
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_frame_beat want;
        bit          ok;
        if (!i_rst_n) begin
            phase    = PH_IDLE;
            func_acc = '0;
            len_acc  = '0;
            fill_ptr = '0;
            xor_acc  = '0;
            max_len  = CFG_MAX_LEN_RST;
            beats_due.delete();
        end else begin
            // compare first: a beat can never stem from an rx byte of the same edge
            if (i_out_valid && i_out_ready) begin
                if (beats_due.size() == 0) begin
                    $display("%0t ns: unexpected result beat, expected none, actual ",
                             $time, "fc=0x%0h len=%0d idx=%0d data=0x%0h last=%b",
                             i_function_code, i_payload_length, i_byte_index,
                             i_payload_byte, i_last_of_frame);
                    fail_count++;
                end else begin
                    want = beats_due.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("function_code", want.function_code, i_function_code);
                    ok &= field_ok("payload_length", want.payload_length, i_payload_length);
                    ok &= field_ok("byte_index", want.byte_index, i_byte_index);
                    ok &= field_ok("payload_byte", want.payload_byte, i_payload_byte);
                    ok &= field_ok("last_of_frame", want.last_of_frame, i_last_of_frame);
                    if (!ok) fail_count++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                max_len = i_cfg_max_len;
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_rx_byte);
            end
        end
        o_fail_count <= fail_count;
        o_beats_due  <= beats_due.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the serial frame decoder with directed frames, then with phases of
// random frames under several payload limits, with random gaps on both
// channels and one long result hold-off. sfd_monitor does the checking; this
// module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import sfd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int DRAIN_CYCLES = 8;      // settling margin after the last due result beat
    localparam int LONG_HOLD    = 400;    // receiver hold-off for the pressure phase
    localparam int PHASE_BEATS  = 8;      // minimum random rx beats counted per phase
    localparam int N_PHASES     = 6;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [RX_W-1:0]      rx_byte = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_max_len = CFG_MAX_LEN_RST;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FUNC_W-1:0]    function_code;
    logic [OUT_LEN_W-1:0] payload_length;
    logic [IDX_W-1:0]     byte_index;
    logic [RX_W-1:0]      payload_byte;
    logic                 last_of_frame;
    int                   fail_count;
    int                   beats_due;

    // stimulus-side view of the limit and the idling mix
    logic [CFG_W-1:0]     cur_limit = CFG_MAX_LEN_RST;
    int unsigned          tx_idle_pct = 20;
    int unsigned          rx_idle_pct = 20;
    bit                   hold_req = 1'b0;
    logic [RX_W-1:0]      payload_q [$];

    serial_frame_decoder DUT (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_rx_byte            (rx_byte),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_max_payload_length (cfg_max_len),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_function_code      (function_code),
        .o_payload_length     (payload_length),
        .o_byte_index         (byte_index),
        .o_payload_byte       (payload_byte),
        .o_last_of_frame      (last_of_frame)
    );

    sfd_monitor u_monitor (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_rx_byte        (rx_byte),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_max_len    (cfg_max_len),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_function_code  (function_code),
        .i_payload_length (payload_length),
        .i_byte_index     (byte_index),
        .i_payload_byte   (payload_byte),
        .i_last_of_frame  (last_of_frame),
        .o_fail_count     (fail_count),
        .o_beats_due      (beats_due)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Pick an idle gap: none most of the time, short ones often, long ones rarely.
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // The decoder clamps the limit to its buffer size.
    function automatic int unsigned eff_limit();
        return (cur_limit > P_PAYLOAD_MAX) ? P_PAYLOAD_MAX : cur_limit;
    endfunction

    // Mostly short payloads, sometimes anything up to the limit, now and then
    // exactly the limit.
    function automatic logic [LEN_W-1:0] pick_len(input int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (lim == 0 || r < 10) return '0;
        if (r < 80) return LEN_W'($urandom_range(1, (lim < 6) ? lim : 6));
        if (r < 95) return LEN_W'($urandom_range(1, lim));
        return LEN_W'(lim);
    endfunction

    // Offer one rx beat, optionally after a gap, and hold it until accepted.
    // Valid is not dropped here, so back-to-back beats keep it high.
    task automatic send_byte(input logic [RX_W-1:0] b);
        int unsigned gap;
        gap = pick_gap(tx_idle_pct);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid, let every due result beat arrive, then wait out the latency.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the payload limit once the decoder has nothing left to emit.
    task automatic set_limit(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid   <= 1'b1;
        cfg_max_len <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_limit  = value;
    endtask

    // Send one frame: header, then payload (from payload_q first, random after)
    // and checksum unless the length is over the limit. A bad frame gets a
    // corrupted checksum.
    task automatic send_frame(input logic [FUNC_W-1:0] func, input logic [LEN_W-1:0] len,
                              input bit good);
        logic [RX_W-1:0] sum;
        logic [RX_W-1:0] b;
        int unsigned     i;
        sum = START_BYTE ^ func[15:8] ^ func[7:0] ^ len[15:8] ^ len[7:0];
        send_byte(START_BYTE);
        send_byte(func[15:8]);
        send_byte(func[7:0]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        if (len != 0 && len > eff_limit()) begin
            payload_q.delete();
        end else begin
            for (i = 0; i < len; i++) begin
                b = (payload_q.size() != 0) ? payload_q.pop_front() : RX_W'($urandom);
                sum ^= b;
                send_byte(b);
            end
            if (!good) sum ^= RX_W'($urandom_range(1, 255));
            send_byte(sum);
        end
    endtask

    // One random chunk of traffic: mostly good frames, some bad checksums,
    // over-length headers, idle noise and truncated frames.
    task automatic send_random_chunk(output int unsigned beats);
        int unsigned       r;
        int unsigned       lim;
        int unsigned       i;
        int unsigned       n;
        logic [FUNC_W-1:0] func;
        logic [LEN_W-1:0]  len;
        logic [RX_W-1:0]   b;
        r     = $urandom_range(0, 99);
        lim   = eff_limit();
        func  = FUNC_W'($urandom);
        beats = 0;
        if (r < 77) begin
            len = pick_len(lim);
            send_frame(func, len, r < 65);
            beats = 6 + len;
        end else if (r < 87) begin
            if ($urandom_range(0, 2) == 0) begin
                len = {8'($urandom_range(1, 255)), 8'($urandom)};
            end else begin
                len = LEN_W'(lim + $urandom_range(1, 16));
            end
            send_frame(func, len, 1'b1);
            beats = 5;
        end else if (r < 95) begin
            // idle noise; never a start byte
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) begin
                b = RX_W'($urandom);
                if (b == START_BYTE) b = 8'h00;
                send_byte(b);
            end
        end else begin
            // cut a frame short; the next frame lands mid-header
            n = $urandom_range(1, 3);
            send_byte(START_BYTE);
            for (i = 0; i < n; i++) send_byte(RX_W'($urandom));
            beats = n + 1;
        end
    endtask

    // Result sink: random gaps, plus one long hold-off when asked for.
    initial begin : result_sink
        bit          hold_taken;
        int unsigned gap;
        hold_taken = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                gap = pick_gap(rx_idle_pct);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end else begin
                    out_ready <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned ph;
        int unsigned ph_beats;
        int unsigned chunk;
        logic [CFG_W-1:0] limits [N_PHASES];

        // hold reset, then release it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part, limit at its reset value ----
        // idle bytes other than the start byte are dropped
        send_byte(8'h00);
        send_byte(8'hFF);
        // zero-length frame: one result with index 0 and data 0
        send_frame(16'h0000, 16'd0, 1'b1);
        // payload extremes with an all-ones function code
        payload_q = '{8'h00, 8'hFF};
        send_frame(16'hFFFF, 16'd2, 1'b1);
        // length with its high byte set: dropped after the header
        send_frame(16'h1234, 16'h0100, 1'b1);
        // checksum mismatch: nothing emitted
        send_frame(16'hABCD, 16'd0, 1'b0);
        // change the limit mid-header; it is applied on the length low byte
        send_byte(START_BYTE);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_byte(8'h00);
        set_limit(7'd2);
        send_byte(8'h03);

        // ---- random phases over several limits ----
        limits = '{7'd0, 7'd127, 7'd1, 7'd64,
                   7'($urandom_range(2, 64)), 7'($urandom_range(65, 127))};
        for (ph = 0; ph < N_PHASES; ph++) begin
            set_limit(limits[ph]);
            // first phase runs without idling on either side
            tx_idle_pct = (ph == 0) ? 0 : $urandom_range(10, 50);
            rx_idle_pct = (ph == 0) ? 0 : $urandom_range(10, 50);
            case (ph)
                0: begin
                    // zero length still passes a zero limit, one byte does not
                    send_frame(FUNC_W'($urandom), 16'd0, 1'b1);
                    send_frame(FUNC_W'($urandom), 16'd1, 1'b1);
                end
                1: begin
                    // limit above the buffer: hold the result channel off while a
                    // full buffer and more frames are offered back to back
                    tx_idle_pct = 0;
                    hold_req    = 1'b1;
                    send_frame(FUNC_W'($urandom), 16'd64, 1'b1);
                    send_frame(FUNC_W'($urandom), 16'd65, 1'b1);
                    send_frame(FUNC_W'($urandom), 16'd3, 1'b1);
                    send_frame(FUNC_W'($urandom), 16'd0, 1'b1);
                    tx_idle_pct = $urandom_range(10, 50);
                end
                2: begin
                    // exactly at the limit passes, one above is dropped
                    send_frame(FUNC_W'($urandom), 16'd1, 1'b1);
                    send_frame(FUNC_W'($urandom), 16'd2, 1'b1);
                end
                default: ;
            endcase
            ph_beats = 0;
            while (ph_beats < PHASE_BEATS) begin
                send_random_chunk(chunk);
                ph_beats += chunk;
            end
        end

        // drain everything still due, then give the verdict
        wait_idle();
        if (fail_count == 0 && beats_due == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: end a hung run.
    initial begin : watchdog
        #(10_000_000);
        $display("timeout with %0d result beats still due", beats_due);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
hdl/sfd_pkg.sv
hdl/sfd_ram.sv
hdl/sfd_ctrl.sv
hdl/sfd_dpath.sv
hdl/serial_frame_decoder.sv
hdl/sfd_checker.sv
verif/sfd_monitor.sv
verif/tb_top.sv
